/* rtl/core/earf_pkg.sv */
`default_nettype none

package earf_pkg;

    typedef enum logic [1:0] {
        VERDICT_IPV4        = 2'd0,
        VERDICT_ARP         = 2'd1,
        VERDICT_REJECT      = 2'd2,
        VERDICT_UNSUPPORTED = 2'd3
    } verdict_t;

    // Register indexes on the configuration port.
    localparam logic REG_OWN_MAC = 1'b0;
    localparam logic REG_OWN_IP  = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] ARP_HW_ETHER   = 16'h0001;
    localparam logic [7:0]  ARP_HW_SIZE    = 8'd6;
    localparam logic [7:0]  ARP_PROTO_SIZE = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
    localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

    localparam int HDR_LEN       = 14;
    localparam int ARP_FRAME_LEN = 60;
    localparam int PASS_MAX      = 2047;

    // Byte offsets of the captured header fields.
    localparam int POS_DEST_END   = 6;
    localparam int POS_TYPE_HI    = 12;
    localparam int POS_TYPE_LO    = 13;
    localparam int POS_HW_HI      = 14;
    localparam int POS_HW_LO      = 15;
    localparam int POS_PROTO_HI   = 16;
    localparam int POS_PROTO_LO   = 17;
    localparam int POS_HW_SIZE    = 18;
    localparam int POS_PROTO_SIZE = 19;
    localparam int POS_OP_HI      = 20;
    localparam int POS_OP_LO      = 21;
    localparam int POS_SMAC_BEGIN = 22;
    localparam int POS_SIP_BEGIN  = 28;
    localparam int POS_TMAC_BEGIN = 32;
    localparam int POS_TMAC_END   = 38;

    typedef struct packed {
        verdict_t     verdict;
        logic [10:0]  pass_length;
        logic         reply_due;
        logic [47:0]  reply_mac;
        logic [31:0]  reply_ip;
        logic [47:0]  peer_mac_out;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/ethernet_arp_receive_filter.sv */
// Ethernet receive filter with ARP responder.
// Frame bytes enter on the s_axis channel, one byte per request, starting at
// the destination MAC; s_axis_tlast marks the final byte of a frame. For every
// frame one verdict leaves on the m_axis channel: verdict in m_axis_tuser, the
// IPv4 payload length, the reply request with the requester's MAC and IPv4
// address, and the learned peer MAC in m_axis_tdata.
// Throughput is one byte per cycle while s_axis_tready is high, frames back
// to back, including frames of a single byte. The verdict is formed in the
// cycle that accepts the last byte from the header captures and registered in
// the output register, or in the skid stage while that register is full.
// The output register is backed by a one-entry skid stage, so bytes keep
// flowing while a verdict waits; s_axis_tready drops only when both hold an
// unclaimed verdict, and rises again as soon as the receiver takes one.
// The user writes own_mac (address 0) and own_ip (address 8) over the APB port
// only while no frame is in flight; the block itself does not enforce this.
// Reset clears the byte counter, the header captures, the learned peer MAC,
// both registers and any pending verdicts.

`default_nettype none

module ethernet_arp_receive_filter #(
    parameter int LENGTH_BITS = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // data_byte[7:0]
    input  wire logic          s_axis_tlast,   // last_byte

    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // pass_length[10:0], reply_due[11], reply_mac[59:12], reply_ip[91:60],
    // peer_mac_out[139:92], zero pad[143:140]
    output logic [143:0]       m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // verdict[1:0]

    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [47:0]            own_mac_reg;
    logic [31:0]            own_ip_reg;

    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_next;
    logic [47:0]            dest_mac_reg, dest_mac_next;
    logic [15:0]            ether_type_reg, ether_type_next;
    logic [15:0]            arp_hw_kind_reg, arp_hw_kind_next;
    logic [15:0]            arp_proto_kind_reg, arp_proto_kind_next;
    logic [7:0]             arp_hw_size_reg, arp_hw_size_next;
    logic [7:0]             arp_proto_size_reg, arp_proto_size_next;
    logic [15:0]            arp_opcode_reg, arp_opcode_next;
    logic [47:0]            arp_sender_mac_reg, arp_sender_mac_next;
    logic [31:0]            arp_sender_ip_reg, arp_sender_ip_next;
    logic [47:0]            arp_target_mac_reg, arp_target_mac_next;
    logic [47:0]            peer_mac_reg, peer_mac_next;

    earf_pkg::result_t      out_reg, skid_reg, result;
    logic                   out_valid_reg, skid_valid_reg;

    logic                   in_accept;
    logic                   produce;
    logic                   cfg_write;
    logic [LENGTH_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] frame_bytes;
    logic [LENGTH_BITS-1:0] len_minus_hdr;
    logic                   addressed_here;
    logic [7:0]             b;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3])
            earf_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            earf_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            default:               prdata = 64'd0;
        endcase
    end

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign produce       = in_accept && s_axis_tlast;
    assign pos           = byte_count_reg;
    assign b             = s_axis_tdata;

    // Header captures at their fixed offsets, including the current byte.
    always_comb
    begin
        dest_mac_next       = dest_mac_reg;
        ether_type_next     = ether_type_reg;
        arp_hw_kind_next    = arp_hw_kind_reg;
        arp_proto_kind_next = arp_proto_kind_reg;
        arp_hw_size_next    = arp_hw_size_reg;
        arp_proto_size_next = arp_proto_size_reg;
        arp_opcode_next     = arp_opcode_reg;
        arp_sender_mac_next = arp_sender_mac_reg;
        arp_sender_ip_next  = arp_sender_ip_reg;
        arp_target_mac_next = arp_target_mac_reg;
        if (in_accept)
        begin
            if (pos < LENGTH_BITS'(earf_pkg::POS_DEST_END))
            begin
                dest_mac_next = {dest_mac_reg[39:0], b};
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_TYPE_HI)
                  || pos == LENGTH_BITS'(earf_pkg::POS_TYPE_LO))
            begin
                ether_type_next = {ether_type_reg[7:0], b};
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_HW_HI)
                  || pos == LENGTH_BITS'(earf_pkg::POS_HW_LO))
            begin
                arp_hw_kind_next = {arp_hw_kind_reg[7:0], b};
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_PROTO_HI)
                  || pos == LENGTH_BITS'(earf_pkg::POS_PROTO_LO))
            begin
                arp_proto_kind_next = {arp_proto_kind_reg[7:0], b};
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_HW_SIZE))
            begin
                arp_hw_size_next = b;
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_PROTO_SIZE))
            begin
                arp_proto_size_next = b;
            end
            else if (pos == LENGTH_BITS'(earf_pkg::POS_OP_HI)
                  || pos == LENGTH_BITS'(earf_pkg::POS_OP_LO))
            begin
                arp_opcode_next = {arp_opcode_reg[7:0], b};
            end
            else if (pos >= LENGTH_BITS'(earf_pkg::POS_SMAC_BEGIN)
                  && pos <  LENGTH_BITS'(earf_pkg::POS_SIP_BEGIN))
            begin
                arp_sender_mac_next = {arp_sender_mac_reg[39:0], b};
            end
            else if (pos >= LENGTH_BITS'(earf_pkg::POS_SIP_BEGIN)
                  && pos <  LENGTH_BITS'(earf_pkg::POS_TMAC_BEGIN))
            begin
                arp_sender_ip_next = {arp_sender_ip_reg[23:0], b};
            end
            else if (pos >= LENGTH_BITS'(earf_pkg::POS_TMAC_BEGIN)
                  && pos <  LENGTH_BITS'(earf_pkg::POS_TMAC_END))
            begin
                arp_target_mac_next = {arp_target_mac_reg[39:0], b};
            end
        end
    end

    assign frame_bytes   = (byte_count_reg < LEN_MAX) ? byte_count_reg + 1'b1 : byte_count_reg;
    assign len_minus_hdr = frame_bytes - LENGTH_BITS'(earf_pkg::HDR_LEN);
    assign addressed_here = (dest_mac_next == earf_pkg::MAC_BROADCAST)
                         || (dest_mac_next == own_mac_reg);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (in_accept)
        begin
            byte_count_next = s_axis_tlast ? '0 : frame_bytes;
        end
    end

    // Verdict for the frame that ends with the current byte.
    always_comb
    begin
        peer_mac_next       = peer_mac_reg;
        result.verdict      = earf_pkg::VERDICT_REJECT;
        result.pass_length  = 11'd0;
        result.reply_due    = 1'b0;
        result.reply_mac    = 48'd0;
        result.reply_ip     = 32'd0;
        priority if (frame_bytes < LENGTH_BITS'(earf_pkg::HDR_LEN))
        begin
            result.verdict = earf_pkg::VERDICT_REJECT;
        end
        else if (ether_type_next == earf_pkg::ETHERTYPE_IPV4)
        begin
            if (addressed_here)
            begin
                result.verdict = earf_pkg::VERDICT_IPV4;
                if (len_minus_hdr > LENGTH_BITS'(earf_pkg::PASS_MAX))
                begin
                    result.pass_length = 11'(earf_pkg::PASS_MAX);
                end
                else
                begin
                    result.pass_length = len_minus_hdr[10:0];
                end
            end
        end
        else if (ether_type_next == earf_pkg::ETHERTYPE_ARP)
        begin
            if (frame_bytes == LENGTH_BITS'(earf_pkg::ARP_FRAME_LEN) && addressed_here)
            begin
                priority if (arp_hw_kind_next != earf_pkg::ARP_HW_ETHER
                          || arp_proto_kind_next != earf_pkg::ETHERTYPE_IPV4)
                begin
                    result.verdict = earf_pkg::VERDICT_ARP;
                end
                else if (arp_hw_size_next == earf_pkg::ARP_HW_SIZE
                      && arp_proto_size_next == earf_pkg::ARP_PROTO_SIZE)
                begin
                    result.verdict = earf_pkg::VERDICT_ARP;
                    if (arp_opcode_next == earf_pkg::ARP_OP_REQUEST)
                    begin
                        peer_mac_next    = arp_sender_mac_next;
                        result.reply_due = 1'b1;
                        result.reply_mac = arp_sender_mac_next;
                        result.reply_ip  = arp_sender_ip_next;
                    end
                    else if (arp_opcode_next == earf_pkg::ARP_OP_REPLY)
                    begin
                        peer_mac_next = arp_sender_mac_next;
                    end
                end
                else
                begin
                    result.verdict = earf_pkg::VERDICT_REJECT;
                end
            end
        end
        else
        begin
            result.verdict = earf_pkg::VERDICT_UNSUPPORTED;
        end
        result.peer_mac_out = peer_mac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg        <= '0;
            own_ip_reg         <= '0;
            byte_count_reg     <= '0;
            dest_mac_reg       <= '0;
            ether_type_reg     <= '0;
            arp_hw_kind_reg    <= '0;
            arp_proto_kind_reg <= '0;
            arp_hw_size_reg    <= '0;
            arp_proto_size_reg <= '0;
            arp_opcode_reg     <= '0;
            arp_sender_mac_reg <= '0;
            arp_sender_ip_reg  <= '0;
            arp_target_mac_reg <= '0;
            peer_mac_reg       <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[3])
                    earf_pkg::REG_OWN_MAC: own_mac_reg <= pwdata[47:0];
                    earf_pkg::REG_OWN_IP:  own_ip_reg  <= pwdata[31:0];
                    default:               own_ip_reg  <= own_ip_reg;
                endcase
            end
            byte_count_reg     <= byte_count_next;
            dest_mac_reg       <= dest_mac_next;
            ether_type_reg     <= ether_type_next;
            arp_hw_kind_reg    <= arp_hw_kind_next;
            arp_proto_kind_reg <= arp_proto_kind_next;
            arp_hw_size_reg    <= arp_hw_size_next;
            arp_proto_size_reg <= arp_proto_size_next;
            arp_opcode_reg     <= arp_opcode_next;
            arp_sender_mac_reg <= arp_sender_mac_next;
            arp_sender_ip_reg  <= arp_sender_ip_next;
            arp_target_mac_reg <= arp_target_mac_next;
            if (produce)
            begin
                peer_mac_reg <= peer_mac_next;
            end

            // A new verdict cannot arrive while the skid stage is full.
            if (!out_valid_reg || m_axis_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= produce;
                end
            end
            else if (produce)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (produce)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.verdict;
    assign m_axis_tdata  = {4'd0, out_reg.peer_mac_out, out_reg.reply_ip,
                            out_reg.reply_mac, out_reg.reply_due, out_reg.pass_length};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a verdict while the output register is empty");

    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (byte_count_reg == '0))
        else $error("byte counter did not restart after the last byte");

    a_reply_is_arp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[11]) |-> (m_axis_tuser == earf_pkg::VERDICT_ARP))
        else $error("reply requested on a frame that is not ARP");

    a_length_is_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[10:0] != 11'd0)
        |-> (m_axis_tuser == earf_pkg::VERDICT_IPV4))
        else $error("payload length given on a frame that is not passed up");

    a_no_verdict_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("pending verdict dropped while the receiver stalls");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_ethernet_arp_receive_filter.sv */
`timescale 1ns / 1ps

module tb_ethernet_arp_receive_filter;

    localparam int LEN_BITS = 11;
    localparam int LEN_MAX = (1 << LEN_BITS) - 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_PRINTED = 50;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;

    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata = '0;
    logic           s_axis_tlast = 1'b0;

    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [143:0]   m_axis_tdata;
    logic [1:0]     m_axis_tuser;

    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [3:0]     paddr = '0;
    logic [63:0]    pwdata = '0;
    logic [63:0]    prdata;
    logic           pready;

    ethernet_arp_receive_filter #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Station address as the filter should currently see it.
    logic [47:0]    cfg_own_mac = '0;

    // Header captures of the filter, mirrored byte by byte.
    int             rx_pos = 0;
    logic [47:0]    cap_dest = '0;
    logic [15:0]    cap_type = '0;
    logic [15:0]    cap_hw = '0;
    logic [15:0]    cap_proto = '0;
    logic [7:0]     cap_hw_size = '0;
    logic [7:0]     cap_proto_size = '0;
    logic [15:0]    cap_op = '0;
    logic [47:0]    cap_smac = '0;
    logic [31:0]    cap_sip = '0;
    logic [47:0]    peer_mac = '0;

    earf_pkg::result_t pending_verdicts[$];
    int             mismatch_count = 0;

    logic [7:0]     frame_buf[$];
    logic           tx_gaps = 1'b0;
    int             burst_left = 0;
    rx_mode_t       rx_mode = RX_ALWAYS;
    int             rx_tick = 0;
    int             hold_left = 0;
    int             idle_cycles = 0;

    function automatic logic addressed_here(input logic [47:0] mac);
        return mac == earf_pkg::MAC_BROADCAST || mac == cfg_own_mac;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // Mirrors one accepted frame byte; the frame's verdict is queued on the last byte.
    task automatic predict_verdict(input logic [7:0] b, input logic last);
        earf_pkg::result_t r;
        int len;
        if (rx_pos < earf_pkg::POS_DEST_END)
            cap_dest = {cap_dest[39:0], b};
        else if (rx_pos == earf_pkg::POS_TYPE_HI || rx_pos == earf_pkg::POS_TYPE_LO)
            cap_type = {cap_type[7:0], b};
        else if (rx_pos == earf_pkg::POS_HW_HI || rx_pos == earf_pkg::POS_HW_LO)
            cap_hw = {cap_hw[7:0], b};
        else if (rx_pos == earf_pkg::POS_PROTO_HI || rx_pos == earf_pkg::POS_PROTO_LO)
            cap_proto = {cap_proto[7:0], b};
        else if (rx_pos == earf_pkg::POS_HW_SIZE)
            cap_hw_size = b;
        else if (rx_pos == earf_pkg::POS_PROTO_SIZE)
            cap_proto_size = b;
        else if (rx_pos == earf_pkg::POS_OP_HI || rx_pos == earf_pkg::POS_OP_LO)
            cap_op = {cap_op[7:0], b};
        else if (rx_pos >= earf_pkg::POS_SMAC_BEGIN && rx_pos < earf_pkg::POS_SIP_BEGIN)
            cap_smac = {cap_smac[39:0], b};
        else if (rx_pos >= earf_pkg::POS_SIP_BEGIN && rx_pos < earf_pkg::POS_TMAC_BEGIN)
            cap_sip = {cap_sip[23:0], b};
        if (rx_pos < LEN_MAX)
            rx_pos++;
        if (last)
        begin
            len = rx_pos;
            rx_pos = 0;
            r = '0;
            r.verdict = earf_pkg::VERDICT_REJECT;
            if (len >= earf_pkg::HDR_LEN)
            begin
                if (cap_type == earf_pkg::ETHERTYPE_IPV4)
                begin
                    if (addressed_here(cap_dest))
                    begin
                        r.verdict = earf_pkg::VERDICT_IPV4;
                        r.pass_length = 11'((len - earf_pkg::HDR_LEN > earf_pkg::PASS_MAX)
                                            ? earf_pkg::PASS_MAX
                                            : len - earf_pkg::HDR_LEN);
                    end
                end
                else if (cap_type == earf_pkg::ETHERTYPE_ARP)
                begin
                    if (len == earf_pkg::ARP_FRAME_LEN && addressed_here(cap_dest))
                    begin
                        if (cap_hw != earf_pkg::ARP_HW_ETHER
                            || cap_proto != earf_pkg::ETHERTYPE_IPV4)
                            r.verdict = earf_pkg::VERDICT_ARP;
                        else if (cap_hw_size == earf_pkg::ARP_HW_SIZE
                                 && cap_proto_size == earf_pkg::ARP_PROTO_SIZE)
                        begin
                            r.verdict = earf_pkg::VERDICT_ARP;
                            if (cap_op == earf_pkg::ARP_OP_REQUEST)
                            begin
                                peer_mac = cap_smac;
                                r.reply_due = 1'b1;
                                r.reply_mac = cap_smac;
                                r.reply_ip = cap_sip;
                            end
                            else if (cap_op == earf_pkg::ARP_OP_REPLY)
                                peer_mac = cap_smac;
                        end
                    end
                end
                else
                    r.verdict = earf_pkg::VERDICT_UNSUPPORTED;
            end
            r.peer_mac_out = peer_mac;
            pending_verdicts.push_back(r);
        end
    endtask

    task automatic check_verdict(input earf_pkg::result_t want);
        if (m_axis_tuser !== want.verdict)
            report_mismatch("verdict", 64'(m_axis_tuser), 64'(want.verdict));
        if (m_axis_tdata[10:0] !== want.pass_length)
            report_mismatch("pass_length", 64'(m_axis_tdata[10:0]), 64'(want.pass_length));
        if (m_axis_tdata[11] !== want.reply_due)
            report_mismatch("reply_due", 64'(m_axis_tdata[11]), 64'(want.reply_due));
        if (m_axis_tdata[59:12] !== want.reply_mac)
            report_mismatch("reply_mac", 64'(m_axis_tdata[59:12]), 64'(want.reply_mac));
        if (m_axis_tdata[91:60] !== want.reply_ip)
            report_mismatch("reply_ip", 64'(m_axis_tdata[91:60]), 64'(want.reply_ip));
        if (m_axis_tdata[139:92] !== want.peer_mac_out)
            report_mismatch("peer_mac_out", 64'(m_axis_tdata[139:92]),
                            64'(want.peer_mac_out));
        if (m_axis_tdata[143:140] !== 4'h0)
            report_mismatch("tdata padding", 64'(m_axis_tdata[143:140]), 64'h0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_verdict(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("unexpected verdict", 64'(m_axis_tuser), 64'h0);
                else
                    check_verdict(pending_verdicts.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: a long hold-off overrides the current stall mode.
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            unique case (rx_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_axis_tready <= ((rx_tick % 9) < 6);
                default:    m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reg_readback(input logic idx, input logic [63:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata, want);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_station(input logic [47:0] mac, input logic [31:0] ip);
        wait_idle();
        reg_write(earf_pkg::REG_OWN_MAC, {16'h0, mac});
        cfg_own_mac = mac;
        reg_write(earf_pkg::REG_OWN_IP, {32'h0, ip});
        reg_readback(earf_pkg::REG_OWN_MAC, {16'h0, mac});
        reg_readback(earf_pkg::REG_OWN_IP, {32'h0, ip});
    endtask

    function automatic logic [47:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [47:0] pick_dest();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return cfg_own_mac;
            4, 5, 6:    return earf_pkg::MAC_BROADCAST;
            7:          return random_mac();
            8:          return cfg_own_mac ^ (48'h1 << $urandom_range(0, 47));
            default:    return earf_pkg::MAC_BROADCAST ^ (48'h1 << $urandom_range(0, 47));
        endcase
    endfunction

    task automatic add_bytes(input logic [63:0] value, input int count);
        for (int i = count - 1; i >= 0; i--)
            frame_buf.push_back(value[8*i +: 8]);
    endtask

    task automatic frame_begin(input logic [47:0] dest, input logic [15:0] ether_kind);
        frame_buf.delete();
        add_bytes(64'(dest), 6);
        add_bytes(64'(random_mac()), 6);
        add_bytes(64'(ether_kind), 2);
    endtask

    // Pads with random bytes or cuts the frame short, then sends it.
    task automatic frame_send(input int len);
        while (frame_buf.size() < len)
            frame_buf.push_back(8'($urandom));
        for (int i = 0; i < len; i++)
            send_byte(frame_buf[i], i == len - 1);
    endtask

    task automatic send_eth(input logic [47:0] dest, input logic [15:0] ether_kind,
                            input int len);
        frame_begin(dest, ether_kind);
        frame_send(len);
    endtask

    task automatic send_arp(input logic [47:0] dest, input logic [15:0] hw,
                            input logic [15:0] proto, input logic [7:0] hw_size,
                            input logic [7:0] proto_size, input logic [15:0] op,
                            input logic [47:0] smac, input logic [31:0] sip, input int len);
        frame_begin(dest, earf_pkg::ETHERTYPE_ARP);
        add_bytes(64'(hw), 2);
        add_bytes(64'(proto), 2);
        add_bytes(64'(hw_size), 1);
        add_bytes(64'(proto_size), 1);
        add_bytes(64'(op), 2);
        add_bytes(64'(smac), 6);
        add_bytes(64'(sip), 4);
        add_bytes(64'(random_mac()), 6);
        add_bytes(64'($urandom), 4);
        frame_send(len);
    endtask

    task automatic send_good_arp(input logic [47:0] dest, input logic [15:0] op);
        send_arp(dest, earf_pkg::ARP_HW_ETHER, earf_pkg::ETHERTYPE_IPV4,
                 earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE, op,
                 random_mac(), 32'($urandom), earf_pkg::ARP_FRAME_LEN);
    endtask

    task automatic test_register_access();
        set_station(random_mac(), 32'($urandom));
    endtask

    task automatic test_runt_frames();
        tx_gaps = 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_eth(cfg_own_mac, earf_pkg::ETHERTYPE_IPV4, 13);
        send_eth(earf_pkg::MAC_BROADCAST, earf_pkg::ETHERTYPE_ARP, 7);
    endtask

    task automatic test_ipv4_frames();
        tx_gaps = 1'b1;
        send_eth(cfg_own_mac, earf_pkg::ETHERTYPE_IPV4, earf_pkg::HDR_LEN);
        send_eth(earf_pkg::MAC_BROADCAST, earf_pkg::ETHERTYPE_IPV4, 20);
        send_eth(cfg_own_mac ^ 48'h1, earf_pkg::ETHERTYPE_IPV4, 16);
        send_eth(48'h0, earf_pkg::ETHERTYPE_IPV4, 15);
    endtask

    task automatic test_arp_frames();
        send_good_arp(earf_pkg::MAC_BROADCAST, earf_pkg::ARP_OP_REQUEST);
        send_good_arp(cfg_own_mac, earf_pkg::ARP_OP_REPLY);
        send_good_arp(cfg_own_mac, 16'hffff);
        send_arp(cfg_own_mac, earf_pkg::ARP_HW_ETHER, earf_pkg::ETHERTYPE_IPV4,
                 earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE, earf_pkg::ARP_OP_REQUEST,
                 random_mac(), 32'($urandom), earf_pkg::ARP_FRAME_LEN - 1);
        send_arp(cfg_own_mac, 16'h0006, earf_pkg::ETHERTYPE_IPV4,
                 earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE, earf_pkg::ARP_OP_REQUEST,
                 random_mac(), 32'($urandom), earf_pkg::ARP_FRAME_LEN);
        send_arp(earf_pkg::MAC_BROADCAST, earf_pkg::ARP_HW_ETHER, earf_pkg::ETHERTYPE_IPV4,
                 earf_pkg::ARP_HW_SIZE, 8'd16, earf_pkg::ARP_OP_REPLY,
                 random_mac(), 32'($urandom), earf_pkg::ARP_FRAME_LEN);
    endtask

    task automatic test_unsupported_types();
        send_eth(cfg_own_mac, 16'h0000, 15);
        send_eth(earf_pkg::MAC_BROADCAST, 16'hffff, 14);
        send_eth(random_mac(), 16'h86dd, 16);
    endtask

    // Receiver holds off while single-byte frames keep coming, so both the output
    // register and the skid stage fill and the input stalls; then the receiver drains.
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_frames(input int frame_count);
        int pick;
        int len;
        logic [15:0] op;
        for (int i = 0; i < frame_count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 13)
                                                  : $urandom_range(14, 40);
                send_eth(pick_dest(), earf_pkg::ETHERTYPE_IPV4, len);
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 4) == 0)
                    op = 16'($urandom);
                else
                    op = $urandom_range(0, 1) ? earf_pkg::ARP_OP_REQUEST
                                              : earf_pkg::ARP_OP_REPLY;
                send_good_arp(pick_dest(), op);
            end
            else if (pick < 87)
            begin
                unique case ($urandom_range(0, 4))
                    0: send_arp(pick_dest(), earf_pkg::ARP_HW_ETHER, earf_pkg::ETHERTYPE_IPV4,
                                earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE,
                                earf_pkg::ARP_OP_REQUEST, random_mac(), 32'($urandom),
                                $urandom_range(14, 80));
                    1: send_arp(pick_dest(), 16'($urandom), earf_pkg::ETHERTYPE_IPV4,
                                earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE,
                                earf_pkg::ARP_OP_REQUEST, random_mac(), 32'($urandom),
                                earf_pkg::ARP_FRAME_LEN);
                    2: send_arp(pick_dest(), earf_pkg::ARP_HW_ETHER, 16'($urandom),
                                earf_pkg::ARP_HW_SIZE, earf_pkg::ARP_PROTO_SIZE,
                                earf_pkg::ARP_OP_REPLY, random_mac(), 32'($urandom),
                                earf_pkg::ARP_FRAME_LEN);
                    3: send_arp(pick_dest(), earf_pkg::ARP_HW_ETHER, earf_pkg::ETHERTYPE_IPV4,
                                8'($urandom), earf_pkg::ARP_PROTO_SIZE,
                                earf_pkg::ARP_OP_REQUEST, random_mac(), 32'($urandom),
                                earf_pkg::ARP_FRAME_LEN);
                    default: send_arp(pick_dest(), earf_pkg::ARP_HW_ETHER,
                                      earf_pkg::ETHERTYPE_IPV4, earf_pkg::ARP_HW_SIZE,
                                      8'($urandom), earf_pkg::ARP_OP_REQUEST, random_mac(),
                                      32'($urandom), earf_pkg::ARP_FRAME_LEN);
                endcase
            end
            else if (pick < 95)
                send_eth(pick_dest(), 16'($urandom), $urandom_range(14, 40));
            else
                send_eth(random_mac(), 16'($urandom), $urandom_range(1, 40));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        rx_mode = RX_RANDOM;

        test_register_access();
        test_runt_frames();
        test_ipv4_frames();
        test_arp_frames();
        test_unsupported_types();
        test_backpressure();

        set_station(random_mac(), 32'($urandom));
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        test_random_frames(2);

        set_station(earf_pkg::MAC_BROADCAST, 32'hffff_ffff);
        tx_gaps = 1'b1;
        rx_mode = RX_PATTERN;
        test_random_frames(1);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* ethernet_arp_receive_filter.f */
rtl/core/earf_pkg.sv
rtl/core/ethernet_arp_receive_filter.sv
tb/sv/tb_ethernet_arp_receive_filter.sv
